### sv/snss_pkg.sv
// ----------------------------------------------------------------------------
// snss_pkg: shared types and helpers for the short name suffix scan unit
// Payload structs, operation and status codes, register indexes, and the
// byte helpers for uppercasing and the rotate-right-and-add name checksum.
// ----------------------------------------------------------------------------
package snss_pkg;

    localparam logic [39:0] BASE_RESET     = 40'h2020202020;
    localparam logic [23:0] EXT_RESET      = 24'h202020;
    localparam logic [7:0]  CH_FREE        = 8'h00;
    localparam logic [7:0]  CH_DELETED     = 8'hE5;
    localparam logic [7:0]  ATTR_LONG_NAME = 8'h0F;
    localparam logic [7:0]  CH_TILDE       = 8'h7E;
    localparam logic [7:0]  CH_SPACE       = 8'h20;
    localparam logic [7:0]  CH_ZERO        = 8'h30;
    localparam logic [6:0]  TAIL_LIMIT     = 7'd99;
    localparam int          NAME_LEN       = 11;

    localparam logic OP_SCAN   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_OVERFLOW = 1'b1;

    localparam logic REG_BASE = 1'b0;
    localparam logic REG_EXT  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [63:0] entry_head;
        logic [7:0]  attribute;
    } t_snss_in;

    typedef struct packed {
        logic [63:0] short_name_head;
        logic [23:0] short_name_ext;
        logic [7:0]  name_checksum;
        logic        status;
    } t_snss_out;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // rotate right, then add the next name byte
    function automatic logic [7:0] sum_step(input logic [7:0] sum, input logic [7:0] b);
        return {sum[0], sum[7:1]} + b;
    endfunction

    // checksum over the five uppercased base bytes and the tilde
    function automatic logic [7:0] base_sum(input logic [39:0] base);
        logic [7:0] s;
        s = 8'h00;
        for (int i = 0; i < 5; i++) begin
            s = sum_step(s, upcase(base[8*i +: 8]));
        end
        s = sum_step(s, CH_TILDE);
        return s;
    endfunction

    localparam logic [7:0] BASE_SUM_RESET = base_sum(BASE_RESET);

endpackage

### sv/short_name_suffix_scan_unit.sv
// ----------------------------------------------------------------------------
// short_name_suffix_scan_unit: FAT 8.3 short name builder with ~N tail
// Scans directory entries for the configured base followed by a numeric
// tail, keeps the highest tail, and on finish emits the next free name.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one transaction
//   per directory entry (operation scan) or a finish request. Scan
//   transactions produce no output; a finish produces one output transaction
//   (o_out_valid / i_out_stall / o_out) with the name, its checksum and
//   status. The APB port sets the base name (address 0) and extension
//   (address 8); write them only while the unit is idle.
// Flow:
//   One transaction is accepted per cycle while o_in_stall is low. An
//   accepted transaction is held in the input register; the scan compare and
//   max update, or the name build and checksum, run between that register and
//   the output register, which offers the finish result.
// Reset:
//   Clears both valid flags and the highest tail; the base and extension
//   return to all spaces.
// Stall:
//   While the output is stalled a finish waits in the input register and
//   o_in_stall rises; scan transactions keep flowing past a held result.
// ----------------------------------------------------------------------------
module short_name_suffix_scan_unit
    import snss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_snss_in    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_snss_out   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [39:0] r_base;
    logic [23:0] r_ext;
    logic [7:0]  r_base_sum;
    logic [6:0]  r_highest;
    logic        r_in_valid;
    t_snss_in    r_in;
    logic        r_out_valid;
    t_snss_out   r_out;

    logic        cfg_wr;
    logic        out_free;
    logic        adv;
    logic        in_accept;

    logic [39:0] base_up;
    logic [23:0] ext_up;
    logic [7:0]  b0;
    logic        skip;
    logic        base_match;
    logic [7:0]  d6_in;
    logic [7:0]  d7_in;
    logic [6:0]  tail;
    logic        tail_update;

    logic [6:0]  next_tail;
    logic        overflow;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  ones_wide;
    logic [7:0]  d6_out;
    logic [7:0]  d7_out;
    logic [7:0]  sum;
    t_snss_out   n_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == REG_EXT) ? {40'h0, r_ext} : {24'h0, r_base};

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            base_up[8*i +: 8] = upcase(r_base[8*i +: 8]);
        end
        for (int i = 0; i < 3; i++) begin
            ext_up[8*i +: 8] = upcase(r_ext[8*i +: 8]);
        end
    end

    // handshake: a scan always drains, a finish needs the output register
    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && ((r_in.operation == OP_SCAN) || out_free);
    assign o_in_stall = r_in_valid && !adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    // scan path
    assign b0         = r_in.entry_head[7:0];
    assign skip       = (b0 == CH_FREE) || (b0 == CH_DELETED) ||
                        (r_in.attribute == ATTR_LONG_NAME);
    assign base_match = (r_in.entry_head[39:0] == base_up) &&
                        (r_in.entry_head[47:40] == CH_TILDE);
    assign d6_in      = r_in.entry_head[55:48];
    assign d7_in      = r_in.entry_head[63:56];

    always_comb begin
        tail = 7'd0;
        if (is_digit(d6_in)) begin
            if (is_digit(d7_in)) begin
                tail = {d6_in[3:0], 3'b000} + {2'b00, d6_in[3:0], 1'b0}
                     + {3'b000, d7_in[3:0]};
            end else if (d7_in == CH_SPACE) begin
                tail = {3'b000, d6_in[3:0]};
            end
        end
    end

    assign tail_update = !skip && base_match && (tail > r_highest);

    // finish path: next tail split into decimal digits by reciprocal multiply
    assign next_tail = r_highest + 7'd1;
    assign overflow  = next_tail > TAIL_LIMIT;
    assign tens_prod = {8'h00, next_tail} * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones_wide = next_tail - {tens, 3'b000} - {2'b00, tens, 1'b0};

    always_comb begin
        if (next_tail < 7'd10) begin
            d6_out = CH_ZERO | {4'h0, next_tail[3:0]};
            d7_out = CH_SPACE;
        end else begin
            d6_out = CH_ZERO | {4'h0, tens};
            d7_out = CH_ZERO | {4'h0, ones_wide[3:0]};
        end
        sum = sum_step(r_base_sum, d6_out);
        sum = sum_step(sum, d7_out);
        for (int i = 0; i < 3; i++) begin
            sum = sum_step(sum, ext_up[8*i +: 8]);
        end
        if (overflow) begin
            n_out.short_name_head = 64'h0;
            n_out.short_name_ext  = 24'h0;
            n_out.name_checksum   = 8'h00;
            n_out.status          = ST_OVERFLOW;
        end else begin
            n_out.short_name_head = {d7_out, d6_out, CH_TILDE, base_up};
            n_out.short_name_ext  = ext_up;
            n_out.name_checksum   = sum;
            n_out.status          = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= BASE_RESET;
            r_ext      <= EXT_RESET;
            r_base_sum <= BASE_SUM_RESET;
        end else if (cfg_wr) begin
            if (paddr[3] == REG_BASE) begin
                r_base     <= pwdata[39:0];
                r_base_sum <= base_sum(pwdata[39:0]);
            end else begin
                r_ext <= pwdata[23:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest <= 7'd0;
        end else if (adv) begin
            if (r_in.operation == OP_FINISH) begin
                r_highest <= 7'd0;
            end else if (tail_update) begin
                r_highest <= tail;
            end
        end
    end

    // hold the result while stalled; load a finish when the slot frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= adv && (r_in.operation == OP_FINISH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && adv && (r_in.operation == OP_FINISH)) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for short_name_suffix_scan_unit
// Streams directory entries and finish requests through the valid/stall
// channels with random gaps and output stalls. A scoreboard class tracks the
// highest tail and predicts each finish result. Base and extension registers
// are rewritten over the APB port between phases and read back.
// ----------------------------------------------------------------------------
module tb;
    import snss_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int IDLE_CYCLES  = 6;
    localparam int PHASE_ITEMS  = 100;
    localparam int FINISH_ODDS  = 12;

    class short_name_tracker;
        logic [39:0] base_cfg;
        logic [23:0] ext_cfg;
        logic [6:0]  top_tail;
        t_snss_out   names_due[$];
        int          errors;

        function new();
            base_cfg = BASE_RESET;
            ext_cfg  = EXT_RESET;
            top_tail = '0;
            errors   = 0;
        endfunction

        static function logic [7:0] to_upper(logic [7:0] c);
            if (c >= "a" && c <= "z") begin
                return c - 8'h20;
            end
            return c;
        endfunction

        static function bit numeral(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
        endfunction

        function void set_register(logic idx, logic [63:0] value);
            if (idx == REG_BASE) begin
                base_cfg = value[39:0];
            end else begin
                ext_cfg = value[23:0];
            end
        endfunction

        function int waiting();
            return names_due.size();
        endfunction

        // update the tail maximum on a scan, queue the expected name on a finish
        function void note_entry(t_snss_in item);
            logic [7:0] lead;
            logic [7:0] d6;
            logic [7:0] d7;
            logic [6:0] tail;
            logic [7:0] name_bytes [0:10];
            logic [7:0] sum;
            t_snss_out  res;
            int         nxt;
            int         i;
            if (item.operation == OP_SCAN) begin
                lead = item.entry_head[7:0];
                if (lead == CH_FREE || lead == CH_DELETED || item.attribute == ATTR_LONG_NAME) begin
                    return;
                end
                for (i = 0; i < 5; i++) begin
                    if (item.entry_head[8*i +: 8] != to_upper(base_cfg[8*i +: 8])) begin
                        return;
                    end
                end
                if (item.entry_head[47:40] != CH_TILDE) begin
                    return;
                end
                d6 = item.entry_head[55:48];
                d7 = item.entry_head[63:56];
                tail = '0;
                if (numeral(d6)) begin
                    if (numeral(d7)) begin
                        tail = 7'(int'(d6 - CH_ZERO) * 10 + int'(d7 - CH_ZERO));
                    end else if (d7 == CH_SPACE) begin
                        tail = 7'(d6 - CH_ZERO);
                    end
                end
                if (tail > top_tail) begin
                    top_tail = tail;
                end
                return;
            end
            nxt = int'(top_tail) + 1;
            top_tail = '0;
            res = '0;
            if (nxt > int'(TAIL_LIMIT)) begin
                res.status = ST_OVERFLOW;
                names_due.push_back(res);
                return;
            end
            for (i = 0; i < 5; i++) begin
                name_bytes[i] = to_upper(base_cfg[8*i +: 8]);
            end
            name_bytes[5] = CH_TILDE;
            if (nxt < 10) begin
                name_bytes[6] = 8'(int'(CH_ZERO) + nxt);
                name_bytes[7] = CH_SPACE;
            end else begin
                name_bytes[6] = 8'(int'(CH_ZERO) + nxt / 10);
                name_bytes[7] = 8'(int'(CH_ZERO) + nxt % 10);
            end
            for (i = 0; i < 3; i++) begin
                name_bytes[8 + i] = to_upper(ext_cfg[8*i +: 8]);
            end
            sum = 8'h00;
            for (i = 0; i < NAME_LEN; i++) begin
                sum = (sum[0] ? 8'h80 : 8'h00) + (sum >> 1) + name_bytes[i];
            end
            for (i = 0; i < 8; i++) begin
                res.short_name_head[8*i +: 8] = name_bytes[i];
            end
            for (i = 0; i < 3; i++) begin
                res.short_name_ext[8*i +: 8] = name_bytes[8 + i];
            end
            res.name_checksum = sum;
            res.status        = ST_OK;
            names_due.push_back(res);
        endfunction

        function void compare_field(string field, logic [63:0] exp, logic [63:0] act);
            if (exp !== act) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp, act);
                errors++;
            end
        endfunction

        function void check_name(t_snss_out got);
            t_snss_out exp;
            if (names_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp = names_due.pop_front();
            compare_field("short_name_head", exp.short_name_head, got.short_name_head);
            compare_field("short_name_ext", 64'(exp.short_name_ext), 64'(got.short_name_ext));
            compare_field("name_checksum", 64'(exp.name_checksum), 64'(got.name_checksum));
            compare_field("status", 64'(exp.status), 64'(got.status));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_snss_in    i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_snss_out   o_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    short_name_tracker sb;
    int                in_calm;
    int                cycle_count;

    short_name_suffix_scan_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // check every result transaction
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_name(o_out);
        end
    end

    // output side: random stall before each result, with calm stretches
    initial begin
        int hold;
        int calm;
        calm = 0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (calm > 0) begin
                calm--;
                hold = 0;
            end else begin
                if ($urandom_range(0, 19) == 0) begin
                    calm = $urandom_range(10, 40);
                end
                hold = $urandom_range(0, 14);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(negedge i_clk);
            while (!(o_out_valid && !i_out_stall)) begin
                @(negedge i_clk);
            end
            @(posedge i_clk);
        end
    end

    function automatic logic [63:0] tail_head(logic [39:0] base, logic [7:0] d6, logic [7:0] d7);
        logic [63:0] head;
        int          i;
        for (i = 0; i < 5; i++) begin
            head[8*i +: 8] = short_name_tracker::to_upper(base[8*i +: 8]);
        end
        head[47:40] = CH_TILDE;
        head[55:48] = d6;
        head[63:56] = d7;
        return head;
    endfunction

    function automatic t_snss_in finish_item();
        t_snss_in item;
        item.operation  = OP_FINISH;
        item.entry_head = {$urandom, $urandom};
        item.attribute  = 8'($urandom);
        return item;
    endfunction

    function automatic t_snss_in scan_item(logic [63:0] head, logic [7:0] attr);
        t_snss_in item;
        item.operation  = OP_SCAN;
        item.entry_head = head;
        item.attribute  = attr;
        return item;
    endfunction

    // mostly well-formed matching entries, the rest broken or noise
    function automatic t_snss_in random_item(logic [39:0] base);
        t_snss_in    item;
        logic [7:0]  d6;
        logic [7:0]  d7;
        logic [7:0]  attr;
        int          kind;
        int          n;
        if ($urandom_range(1, FINISH_ODDS) == 1) begin
            return finish_item();
        end
        attr = 8'($urandom);
        if (attr == ATTR_LONG_NAME) begin
            attr = 8'h20;
        end
        kind = $urandom_range(0, 99);
        n = (kind < 6) ? $urandom_range(97, 99) : $urandom_range(0, 99);
        if ($urandom_range(0, 1) == 1) begin
            d6 = 8'(int'(CH_ZERO) + n / 10);
            d7 = 8'(int'(CH_ZERO) + n % 10);
        end else begin
            d6 = 8'(int'(CH_ZERO) + n % 10);
            d7 = CH_SPACE;
        end
        if (kind >= 60 && kind < 70) begin
            d6 = ($urandom_range(0, 1) == 1) ? d6 : 8'($urandom);
            d7 = 8'($urandom);
        end
        item = scan_item(tail_head(base, d6, d7), attr);
        if (kind >= 70 && kind < 75) begin
            item.entry_head[47:40] = 8'($urandom);
        end else if (kind >= 75 && kind < 80) begin
            item.attribute = ATTR_LONG_NAME;
        end else if (kind >= 80 && kind < 85) begin
            item.entry_head[7:0] = ($urandom_range(0, 1) == 1) ? CH_FREE : CH_DELETED;
        end else if (kind >= 85 && kind < 90) begin
            item.entry_head = item.entry_head ^ (64'd1 << $urandom_range(0, 39));
        end else if (kind >= 90) begin
            item.entry_head = {$urandom, $urandom};
        end
        return item;
    endfunction

    task automatic send_item(t_snss_in item);
        int gap;
        if (in_calm > 0) begin
            in_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 19) == 0) begin
                in_calm = $urandom_range(10, 40);
            end
            gap = $urandom_range(0, 14);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        @(negedge i_clk);
        while (o_in_stall) begin
            @(negedge i_clk);
        end
        sb.note_entry(item);
        @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        repeat (count) send_item(random_item(sb.base_cfg));
    endtask

    // drain results, then give the pipeline time to retire trailing scans
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.waiting() > 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [63:0] value);
        logic [63:0] mask;
        logic [63:0] got;
        mask = (idx == REG_BASE) ? 64'hFF_FFFF_FFFF : 64'hFF_FFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        sb.set_register(idx, value & mask);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) begin
            @(negedge i_clk);
        end
        got = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== (value & mask)) begin
            $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                     $time, idx, value & mask, got & mask);
            sb.errors++;
        end
    endtask

    task automatic directed_items();
        logic [39:0] b;
        b = sb.base_cfg;
        send_item(scan_item({64{1'b1}}, 8'hFF) ^ {1'b1, 72'd0});
        send_item(scan_item(tail_head(b, "5", CH_SPACE), 8'h00));
        send_item(finish_item());
        send_item(scan_item(tail_head(b, "9", CH_SPACE), 8'h20));
        send_item(finish_item());
        send_item(scan_item(tail_head(b, "9", "9"), 8'h01));
        send_item(finish_item());
        send_item('{operation: OP_FINISH, entry_head: 64'd0, attribute: 8'h00});
        send_item(scan_item(tail_head(b, "9", "8"), 8'h10));
        send_item(scan_item(tail_head(b, "4", "2"), 8'h0E));
        send_item(finish_item());
        send_item(scan_item(tail_head(b, "7", "x"), 8'h00));
        send_item(scan_item(tail_head(b, "x", "7"), 8'h00));
        send_item(scan_item(tail_head(b, "5", "0"), ATTR_LONG_NAME));
        send_item(scan_item(tail_head(b, "5", "0") ^ 64'h0000_5300_0000_0000, 8'h00));
        send_item(finish_item());
        send_item(scan_item({64{1'b1}}, 8'h00));
        send_item(scan_item(64'd0, 8'h00));
        send_item(scan_item(tail_head(b, "3", CH_SPACE), 8'h80));
        send_item(scan_item(tail_head(b, "0", CH_SPACE), 8'h7F));
        send_item(finish_item());
        send_item(scan_item(tail_head(b, "0", "0"), 8'h00));
        send_item(finish_item());
    endtask

    logic [39:0] phase_base [0:5] = '{40'h6E656C6966, 40'h417B607A61, 40'h0000000000,
                                      40'hFFFFFFFFFF, 40'h3132617AE5, 40'h454C49464D};
    logic [23:0] phase_ext  [0:5] = '{24'h747874, 24'h5B405A, 24'h000000,
                                      24'hFFFFFF, 24'h7A6161, 24'h4E4942};

    initial begin
        sb          = new();
        in_calm     = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values first: base and extension all spaces
        directed_items();
        random_phase(PHASE_ITEMS);

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            write_register(REG_BASE, {24'd0, phase_base[p]});
            write_register(REG_EXT, {40'd0, phase_ext[p]});
            random_phase(PHASE_ITEMS);
        end

        // random setting, junk in the unused upper data bits
        wait_idle();
        write_register(REG_BASE, {$urandom, $urandom});
        write_register(REG_EXT, {$urandom, $urandom});
        random_phase(PHASE_ITEMS);

        i_in_valid <= 1'b0;
        while (sb.waiting() > 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_CYCLES + 4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### short_name_suffix_scan_unit.f
sv/snss_pkg.sv
sv/short_name_suffix_scan_unit.sv
test/tb.sv
